@@ rtl/assert_macros.svh @@
// assertion macros used by the port-level checker file
// depends on nothing; every macro reports through $error
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle, off during reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after reset is high
`define ASSERT_AFTER_RESET(label, clk, rst, cons, msg) \
  label: assert property (@(posedge clk) (rst) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/rope_pkg.sv @@
// shared constants, payload types and the cordic angle table
// for the rotary position embedding block; depends on nothing
package rope_pkg;

  localparam int PAIRS        = 64;
  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_ENTRIES = 24;
  localparam int STEPS_USED   = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
  localparam int IDX_W        = (PAIRS > 1) ? $clog2(PAIRS) : 1;
  localparam int GAIN_Q16     = 39797;
  localparam int XW           = 34;
  localparam int ZW           = 33;
  localparam int SHIFT_W      = 5;

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_ROTATE = 1'b1;

  localparam logic signed [15:0] SAT_MAX = 16'sh7fff;
  localparam logic signed [15:0] SAT_MIN = 16'sh8000;

  typedef struct packed {
    logic               func;
    logic [5:0]         pair_index;
    logic [15:0]        position;
    logic signed [15:0] first_value;
    logic signed [15:0] second_value;
    logic [31:0]        frequency_word;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] rotated_first;
    logic signed [15:0] rotated_second;
    logic               saturated;
  } out_item_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_t;

  // atan(2^-i) in turns, q0.32
  function automatic logic [31:0] atan_turns(input logic [SHIFT_W-1:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/rope_front.sv @@
// front end: frequency table memory, phase multiply, quadrant fold and gain
// depends on rope_pkg
module rope_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  rope_pkg::in_item_t item,
  output logic               out_valid,
  input  logic               out_ready,
  output rope_pkg::cordic_t  out_data
);
  import rope_pkg::*;

  logic [31:0] mem [0:PAIRS-1];

  logic [7:0]       idx_ext;
  logic [IDX_W-1:0] idx;
  logic             idx_ok;
  logic             accept;
  logic             en1, en2, en3;

  // stage 1: table read
  logic               v1;
  logic [15:0]        pos1;
  logic signed [15:0] a1, b1;
  logic               ok1;
  logic [31:0]        freq1;

  // stage 2: phase
  logic               v2;
  logic [31:0]        phase2;
  logic signed [15:0] a2, b2;
  logic [47:0]        prod;

  // stage 3: folded and scaled
  logic               v3;
  cordic_t            c3;
  logic signed [16:0] a17, b17, x0, y0;
  logic signed [17:0] gain;
  logic signed [34:0] xg, yg;

  assign idx_ext    = 8'(item.pair_index);
  assign idx        = idx_ext[IDX_W-1:0];
  assign idx_ok     = (32'(item.pair_index) < PAIRS);
  assign en3        = !v3 || out_ready;
  assign en2        = !v2 || en3;
  assign en1        = !v1 || en2;
  assign item_ready = en1;
  assign accept     = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (accept && item.func == FUNC_LOAD && idx_ok) begin
      mem[idx] <= item.frequency_word;
    end
    if (accept && item.func == FUNC_ROTATE) begin
      freq1 <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= accept && item.func == FUNC_ROTATE;
      end
      if (en2) begin
        v2 <= v1;
      end
      if (en3) begin
        v3 <= v2;
      end
    end
  end

  assign prod = 48'(pos1) * 48'(freq1);

  always_comb begin
    a17  = 17'(a2);
    b17  = 17'(b2);
    gain = 18'(GAIN_Q16);
    unique case (phase2[31:30])
      2'd0: begin x0 = a17;  y0 = b17;  end
      2'd1: begin x0 = -b17; y0 = a17;  end
      2'd2: begin x0 = -a17; y0 = -b17; end
      default: begin x0 = b17; y0 = -a17; end
    endcase
    xg = 35'(x0) * 35'(gain);
    yg = 35'(y0) * 35'(gain);
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      pos1 <= item.position;
      a1   <= item.first_value;
      b1   <= item.second_value;
      ok1  <= idx_ok;
    end
    if (en2) begin
      phase2 <= ok1 ? prod[31:0] : 32'd0;
      a2     <= a1;
      b2     <= b1;
    end
    if (en3) begin
      c3.x <= XW'(xg);
      c3.y <= XW'(yg);
      c3.z <= ZW'({2'b00, phase2[29:0]});
    end
  end

  assign out_valid = v3;
  assign out_data  = c3;

endmodule

@@ rtl/rope_cordic_step.sv @@
// one registered cordic rotation step; the step index is tied per instance
// depends on rope_pkg
module rope_cordic_step (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [rope_pkg::SHIFT_W-1:0]     step_index,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  rope_pkg::cordic_t                in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output rope_pkg::cordic_t                out_data
);
  import rope_pkg::*;

  logic                 v;
  cordic_t              c;
  cordic_t              nxt;
  logic signed [XW-1:0] dx, dy;
  logic signed [ZW-1:0] ang;
  logic                 en;

  assign en       = !v || out_ready;
  assign in_ready = en;

  always_comb begin
    dx  = in_data.y >>> step_index;
    dy  = in_data.x >>> step_index;
    ang = ZW'(atan_turns(step_index));
    // zero residual rotates the positive way
    if (!in_data.z[ZW-1]) begin
      nxt.x = in_data.x - dx;
      nxt.y = in_data.y + dy;
      nxt.z = in_data.z - ang;
    end else begin
      nxt.x = in_data.x + dx;
      nxt.y = in_data.y - dy;
      nxt.z = in_data.z + ang;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (en) begin
      v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c <= nxt;
    end
  end

  assign out_valid = v;
  assign out_data  = c;

endmodule

@@ rtl/rope_round.sv @@
// output stage: round half up to q1.15 and saturate
// depends on rope_pkg
module rope_round (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  rope_pkg::cordic_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rope_pkg::out_item_t out_data
);
  import rope_pkg::*;

  logic                 v;
  out_item_t            r;
  logic signed [XW-1:0] sx, sy, rx, ry;
  logic                 hx, lx, hy, ly;
  logic                 en;

  assign en       = !v || out_ready;
  assign in_ready = en;

  always_comb begin
    sx = in_data.x + XW'(32768);
    sy = in_data.y + XW'(32768);
    rx = sx >>> 16;
    ry = sy >>> 16;
    hx = rx > XW'(SAT_MAX);
    lx = rx < XW'(SAT_MIN);
    hy = ry > XW'(SAT_MAX);
    ly = ry < XW'(SAT_MIN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (en) begin
      v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r.rotated_first  <= hx ? SAT_MAX : (lx ? SAT_MIN : rx[15:0]);
      r.rotated_second <= hy ? SAT_MAX : (ly ? SAT_MIN : ry[15:0]);
      r.saturated      <= hx || lx || hy || ly;
    end
  end

  assign out_valid = v;
  assign out_data  = r;

endmodule

@@ rtl/rotary_position_embedding.sv @@
// Rotary position embedding, one channel pair per item, fully pipelined: one item
// per clock when the output is not stalled; load items write the 64 x 32 frequency
// table through its single write port and give no result. Stages: table read, phase
// multiply (16 x 32), quadrant fold and gain multiply, one register per cordic step,
// then rounding and saturation. Every stage holds under back-pressure independently,
// so bubbles close up. A rotate may read an entry only after it was written; the
// table has no reset.
// depends on rope_pkg, rope_front, rope_cordic_step, rope_round
module rotary_position_embedding (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  rope_pkg::in_item_t  item,
  output logic                result_valid,
  input  logic                result_ready,
  output rope_pkg::out_item_t result
);
  import rope_pkg::*;

  cordic_t c_data  [0:STEPS_USED];
  logic    c_valid [0:STEPS_USED];
  logic    c_ready [0:STEPS_USED];

  rope_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .out_valid  (c_valid[0]),
    .out_ready  (c_ready[0]),
    .out_data   (c_data[0])
  );

  for (genvar k = 0; k < STEPS_USED; k++) begin : g_step
    rope_cordic_step u_step (
      .clk        (clk),
      .rst        (rst),
      .step_index (SHIFT_W'(k)),
      .in_valid   (c_valid[k]),
      .in_ready   (c_ready[k]),
      .in_data    (c_data[k]),
      .out_valid  (c_valid[k+1]),
      .out_ready  (c_ready[k+1]),
      .out_data   (c_data[k+1])
    );
  end

  rope_round u_round (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (c_valid[STEPS_USED]),
    .in_ready  (c_ready[STEPS_USED]),
    .in_data   (c_data[STEPS_USED]),
    .out_valid (result_valid),
    .out_ready (result_ready),
    .out_data  (result)
  );

endmodule

@@ rtl/rope_checker.sv @@
// port-level checks for the rotary position embedding block, bound to the top
// depends on rope_pkg and assert_macros.svh
`include "assert_macros.svh"

module rope_port_checks (
  input logic                clk,
  input logic                rst,
  input logic                item_ready,
  input logic                result_valid,
  input logic                result_ready,
  input rope_pkg::out_item_t result
);
  import rope_pkg::*;

  logic stalled_prev;

  always_ff @(posedge clk) begin
    if (rst) begin
      stalled_prev <= 1'b0;
    end else begin
      stalled_prev <= result_valid && !result_ready;
    end
  end

  `ASSERT_AFTER_RESET(a_empty_after_reset, clk, rst, !result_valid, "result after reset")
  `ASSERT_AFTER_RESET(a_ready_after_reset, clk, rst, item_ready, "not ready after reset")
  `ASSERT_IMPLIES(a_sat_at_rail, clk, rst, result_valid && result.saturated, result.rotated_first == SAT_MAX || result.rotated_first == SAT_MIN || result.rotated_second == SAT_MAX || result.rotated_second == SAT_MIN, "saturated flag off the rails")
  `ASSERT_IMPLIES(a_result_holds, clk, rst, stalled_prev, result_valid && result == $past(result), "stalled result changed")

endmodule

bind rotary_position_embedding rope_port_checks u_rope_port_checks (
  .clk          (clk),
  .rst          (rst),
  .item_ready   (item_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

@@ sim/rope_checker.sv @@
`timescale 1ns / 1ps
// checker for the rotary position embedding block: mirrors the frequency table,
// predicts each rotate result and compares it with the output channel; uses rope_pkg
module rope_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  logic                item_ready,
  input  rope_pkg::in_item_t  item,
  input  logic                result_valid,
  input  logic                result_ready,
  input  rope_pkg::out_item_t result,
  output int                  errors,
  output int                  pending,
  output int                  checked
);
  import rope_pkg::*;

  localparam logic [31:0] ANGLE_TURNS [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };
  localparam int NSTEPS = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;

  logic [31:0] freq_mirror [PAIRS];
  out_item_t   rotated_q [$];

  function automatic longint round_clamp(longint v, inout logic clamped);
    longint r;
    r = (v + 64'sd32768) >>> 16;
    if (r > 32767) begin
      clamped = 1'b1;
      r = 32767;
    end else if (r < -32768) begin
      clamped = 1'b1;
      r = -32768;
    end
    return r;
  endfunction

  function automatic out_item_t rotate_pair(logic [15:0] pos, logic [31:0] freq,
                                            logic signed [15:0] a, logic signed [15:0] b);
    logic [47:0] prod;
    logic [31:0] phase;
    longint      x, y, z, t, dx, dy;
    logic        clamped;
    out_item_t   o;
    prod  = pos * freq;
    phase = prod[31:0];
    x = a;
    y = b;
    // exact quarter-turn fold from the top two phase bits
    case (phase[31:30])
      2'd1: begin
        t = x; x = -y; y = t;
      end
      2'd2: begin
        x = -x; y = -y;
      end
      2'd3: begin
        t = x; x = y; y = -t;
      end
      default: ;
    endcase
    x = x * GAIN_Q16;
    y = y * GAIN_Q16;
    z = {34'd0, phase[29:0]};
    for (int i = 0; i < NSTEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - ANGLE_TURNS[i];
      end else begin
        x = x + dx; y = y - dy; z = z + ANGLE_TURNS[i];
      end
    end
    clamped = 1'b0;
    o.rotated_first  = 16'(round_clamp(x, clamped));
    o.rotated_second = 16'(round_clamp(y, clamped));
    o.saturated      = clamped;
    return o;
  endfunction

  assign pending = rotated_q.size();

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      errors  <= 0;
      checked <= 0;
      rotated_q.delete();
    end else begin
      if (item_valid && item_ready) begin
        if (item.func == FUNC_LOAD) begin
          if (item.pair_index < PAIRS) freq_mirror[item.pair_index] = item.frequency_word;
        end else begin
          rotated_q.push_back(rotate_pair(item.position,
            (item.pair_index < PAIRS) ? freq_mirror[item.pair_index] : 32'd0,
            item.first_value, item.second_value));
        end
      end
      if (result_valid && result_ready) begin
        checked <= checked + 1;
        if (rotated_q.size() == 0) begin
          if (errors < 10) $display("unexpected result item %p", result);
          errors <= errors + 1;
        end else begin
          want = rotated_q.pop_front();
          if (result !== want) begin
            if (errors < 10)
              $display("mismatch: expected first %0d second %0d sat %0b, got %0d %0d %0b",
                       want.rotated_first, want.rotated_second, want.saturated,
                       result.rotated_first, result.rotated_second, result.saturated);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

@@ sim/rotary_position_embedding_tb.sv @@
`timescale 1ns / 1ps
// top of the rotary position embedding testbench: clock, reset, stimulus, verdict
// depends on rope_pkg, rope_checker and the rotary_position_embedding block
module rotary_position_embedding_tb;
  import rope_pkg::*;

  logic      clk;
  logic      rst;
  logic      item_valid;
  logic      item_ready;
  in_item_t  item;
  logic      result_valid;
  logic      result_ready;
  out_item_t result;
  int        errors, pending, checked;

  int  idle_pct;
  int  stall_pct;
  bit  long_hold;
  bit  loaded [PAIRS];
  int  loads_sent, rotates_sent;

  rotary_position_embedding u_dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result)
  );

  rope_checker u_chk (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .errors(errors), .pending(pending), .checked(checked)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("timeout");
    $display("FAIL");
    $finish;
  end

  // receiver: random back-pressure, with one long hold-off on request
  initial begin
    result_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        result_ready <= 1'b0;
        repeat (300) @(posedge clk);
        long_hold = 1'b0;
      end else begin
        result_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic in_item_t make_item(logic f, logic [5:0] idx, logic [15:0] pos,
                                         logic [15:0] a, logic [15:0] b, logic [31:0] w);
    in_item_t it;
    it.func = f;
    it.pair_index = idx;
    it.position = pos;
    it.first_value = a;
    it.second_value = b;
    it.frequency_word = w;
    return it;
  endfunction

  task automatic send_item(in_item_t it);
    if ($urandom_range(99) < idle_pct) begin
      item_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (!item_ready);
    if (it.func == FUNC_LOAD) begin
      loaded[it.pair_index] = 1'b1;
      loads_sent++;
    end else begin
      rotates_sent++;
    end
  endtask

  function automatic logic [15:0] pick_value();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_random();
    logic [5:0] idx;
    logic [15:0] pos;
    logic [31:0] w;
    pos = ($urandom_range(9) == 0) ? (($urandom_range(1) == 1) ? 16'hffff : 16'h0000)
                                   : 16'($urandom);
    w = ($urandom_range(4) == 0) ? 32'($urandom_range(65535)) : $urandom;
    if ($urandom_range(3) == 0) begin
      send_item(make_item(FUNC_LOAD, 6'($urandom), pos, pick_value(), pick_value(), w));
    end else begin
      // rotate only entries that have been written
      do idx = 6'($urandom); while (!loaded[idx]);
      send_item(make_item(FUNC_ROTATE, idx, pos, pick_value(), pick_value(), w));
    end
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    idle_pct = 0;
    stall_pct = 0;
    long_hold = 1'b0;
    loads_sent = 0;
    rotates_sent = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: zero, full and quadrant frequencies, extreme inputs
    send_item(make_item(FUNC_LOAD, 6'd0, 16'd0, 16'h0, 16'h0, 32'h00000000));
    send_item(make_item(FUNC_LOAD, 6'd63, 16'hffff, 16'hffff, 16'hffff, 32'hffffffff));
    send_item(make_item(FUNC_LOAD, 6'd1, 16'd0, 16'h0, 16'h0, 32'h40000000));
    send_item(make_item(FUNC_LOAD, 6'd2, 16'd0, 16'h0, 16'h0, 32'h80000000));
    send_item(make_item(FUNC_LOAD, 6'd3, 16'd0, 16'h0, 16'h0, 32'hc0000000));
    send_item(make_item(FUNC_LOAD, 6'd42, 16'd0, 16'h0, 16'h0, 32'h20000000));
    send_item(make_item(FUNC_LOAD, 6'd21, 16'd0, 16'h0, 16'h0, $urandom));
    send_item(make_item(FUNC_ROTATE, 6'd0, 16'd0, 16'h7fff, 16'h7fff, 32'h0));
    send_item(make_item(FUNC_ROTATE, 6'd0, 16'hffff, 16'h8000, 16'h8000, 32'hffffffff));
    send_item(make_item(FUNC_ROTATE, 6'd63, 16'hffff, 16'h8000, 16'h8000, 32'h0));
    send_item(make_item(FUNC_ROTATE, 6'd63, 16'd1, 16'h7fff, 16'h8000, 32'h0));
    send_item(make_item(FUNC_ROTATE, 6'd1, 16'd1, 16'h8000, 16'h7fff, 32'h0));
    send_item(make_item(FUNC_ROTATE, 6'd2, 16'd1, 16'h8000, 16'h0000, 32'h0));
    send_item(make_item(FUNC_ROTATE, 6'd3, 16'd1, 16'h0000, 16'h8000, 32'h0));
    send_item(make_item(FUNC_ROTATE, 6'd3, 16'd3, 16'h4000, 16'hc000, 32'h0));
    // eighth turn on full-scale inputs pushes past the range
    send_item(make_item(FUNC_ROTATE, 6'd42, 16'd1, 16'h8000, 16'h8000, 32'h0));
    send_item(make_item(FUNC_ROTATE, 6'd42, 16'd1, 16'h7fff, 16'h7fff, 32'h0));
    send_item(make_item(FUNC_ROTATE, 6'd42, 16'd3, 16'h7fff, 16'h8000, 32'h0));
    send_item(make_item(FUNC_ROTATE, 6'd21, 16'($urandom), 16'h0000, 16'h0000, 32'h0));
    send_item(make_item(FUNC_ROTATE, 6'd21, 16'($urandom), 16'($urandom), 16'($urandom),
                        32'h0));

    for (int mode = 0; mode < 4; mode++) begin
      idle_pct  = (mode == 1) ? 53 : (mode == 3) ? 13 : 0;
      stall_pct = (mode == 2) ? 53 : (mode == 3) ? 13 : 0;
      for (int n = 0; n < 150; n++) begin
        if (mode == 0 && n == 40) long_hold = 1'b1;
        send_random();
      end
      // sender waits for the pipeline to empty between phases
      drain();
    end

    drain();
    repeat (40) @(posedge clk);
    $display("sent %0d loads and %0d rotates, %0d results checked, %0d errors",
             loads_sent, rotates_sent, checked, errors);
    $display("covered quadrant folds, saturation, long output stall and four idle mixes");
    if (errors == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

@@ files.f @@
+incdir+rtl
rtl/rope_pkg.sv
rtl/rope_front.sv
rtl/rope_cordic_step.sv
rtl/rope_round.sv
rtl/rotary_position_embedding.sv
rtl/rope_checker.sv
sim/rope_checker.sv
sim/rotary_position_embedding_tb.sv
